// ----- design/l3g_pkg.sv -----
package l3g_pkg;

    localparam int MAX_DIM     = 16;
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int DIM_W       = COORD_W + 1;
    localparam int ROW_W       = MAX_DIM;
    localparam int ROW_ADDR_W  = 2 * COORD_W;
    localparam int ROW_COUNT   = MAX_DIM * MAX_DIM;
    localparam int CNT_W       = 5;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int TAP_W       = 4;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_DEPTH  = 2'd2;

    localparam logic [CNT_W-1:0] KEEP_COUNT  = 5'd2;
    localparam logic [CNT_W-1:0] BIRTH_COUNT = 5'd3;

    typedef struct packed {
        logic clear;
        logic accum;
        logic center;
    } lane_ctrl_t;

endpackage

// ----- design/l3g_ram.sv -----
module l3g_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/l3g_lanes.sv -----
module l3g_lanes (
    input  logic                      clk,
    input  logic                      rst_n,
    input  l3g_pkg::lane_ctrl_t       ctrl,
    input  logic [l3g_pkg::ROW_W-1:0] row,
    input  logic [l3g_pkg::ROW_W-1:0] live,
    output logic [l3g_pkg::ROW_W-1:0] next_row
);
    import l3g_pkg::*;

    logic [CNT_W-1:0] count_reg  [ROW_W];
    logic [CNT_W-1:0] count_next [ROW_W];
    logic [1:0]       tap_sum    [ROW_W];
    logic [ROW_W+1:0] pad;

    // Each lane adds the three cells of the row around its column; the center
    // row leaves out the cell itself.
    always_comb
    begin
        pad = {1'b0, row, 1'b0};
        for (int i = 0; i < ROW_W; i++)
        begin
            tap_sum[i] = {1'b0, pad[i]} + {1'b0, pad[i+2]}
                         + {1'b0, pad[i+1] & ~ctrl.center};
            if (ctrl.clear)
            begin
                count_next[i] = '0;
            end
            else if (ctrl.accum)
            begin
                count_next[i] = count_reg[i] + CNT_W'(tap_sum[i]);
            end
            else
            begin
                count_next[i] = count_reg[i];
            end
            if (live[i])
            begin
                next_row[i] = (count_reg[i] == KEEP_COUNT) || (count_reg[i] == BIRTH_COUNT);
            end
            else
            begin
                next_row[i] = (count_reg[i] == BIRTH_COUNT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROW_W; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < ROW_W; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

// ----- design/life_3d_generation_step.sv -----
// Channel   Direction  Signals                     Beat contents
// s_*       in         s_tvalid s_tready s_tdata   one command: write, read or generation
// m_*       out        m_tvalid m_tready m_tdata   one result per command
// cfg_*     in         cfg_we cfg_index cfg_data   grid width, height, depth
//
// A write or read reads the addressed row, then writes it back or picks out the cell.
// A generation takes, per row in use, nine row reads on the grid memory port, one
// accumulate and one write, then a copy-back pass over every row in use.
// Reset clears the grid at once through one valid flop per row; no clearing pass.
// s_tready is high only while no command is in progress. A stalled result holds in the
// output register while the next command is accepted.
module life_3d_generation_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[1:0], x[5:2], y[9:6], z[13:10], value[14], zero[15]
    input  logic [l3g_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_value[0], out_of_range[1], zero[7:2]
    output logic [l3g_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [l3g_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [l3g_pkg::DIM_W-1:0]       cfg_data
);
    import l3g_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RW,
        S_GEN,
        S_GEN_WR,
        S_COPY,
        S_COPY_END,
        S_RESP
    } state_t;

    localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;
    localparam logic [TAP_W-1:0] TAP_DONE   = 4'd9;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]      gw_reg, gh_reg, gd_reg;
    logic [DIM_W-1:0]      gw_use, gh_use, gd_use;

    logic [OP_W-1:0]       op_reg, op_next;
    logic [COORD_W-1:0]    x_reg, x_next;
    logic [COORD_W-1:0]    y_reg, y_next;
    logic [COORD_W-1:0]    z_reg, z_next;
    logic                  value_reg, value_next;
    logic [COORD_W-1:0]    gy_reg, gy_next;
    logic [COORD_W-1:0]    gz_reg, gz_next;
    logic [TAP_W-1:0]      tap_reg, tap_next;
    logic                  acc_pend_reg, acc_pend_next;
    logic                  tap_ok_reg, tap_ok_next;
    logic                  tap_center_reg, tap_center_next;
    logic                  valid_rd_reg, valid_rd_next;
    logic [ROW_COUNT-1:0]  row_valid_reg, row_valid_next;
    logic                  cp_pend_reg, cp_pend_next;
    logic [ROW_ADDR_W-1:0] cp_addr_reg, cp_addr_next;
    logic [ROW_W-1:0]      center_raw_reg, center_raw_next;
    logic                  res_value_reg, res_value_next;
    logic                  res_oor_reg, res_oor_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_cell_reg, m_cell_next;
    logic                  m_oor_reg, m_oor_next;

    logic [OP_W-1:0]       in_op;
    logic [COORD_W-1:0]    in_x, in_y, in_z;
    logic                  in_value;
    logic                  in_hit;
    logic                  dims_nonzero;

    logic [ROW_W-1:0]      xmask;
    logic [ROW_W-1:0]      cell_row;
    logic [ROW_W-1:0]      lane_row;
    logic [ROW_W-1:0]      lane_next;
    lane_ctrl_t            lane_ctrl;

    logic [1:0]            tap_dz, tap_dy;
    logic [DIM_W-1:0]      tap_z, tap_y;
    logic                  gy_last, gz_last;
    logic [COORD_W-1:0]    gy_adv, gz_adv;

    logic                  cell_we;
    logic [ROW_ADDR_W-1:0] cell_waddr, cell_raddr;
    logic [ROW_W-1:0]      cell_wdata, cell_rdata;
    logic                  nxt_we;
    logic [ROW_ADDR_W-1:0] nxt_waddr, nxt_raddr;
    logic [ROW_W-1:0]      nxt_wdata, nxt_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= DIM_W'(MAX_DIM);
            gh_reg <= DIM_W'(MAX_DIM);
            gd_reg <= DIM_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  gw_reg <= cfg_data;
                CFG_GRID_HEIGHT: gh_reg <= cfg_data;
                CFG_GRID_DEPTH:  gd_reg <= cfg_data;
                default:         gw_reg <= gw_reg;
            endcase
        end
    end

    assign gw_use = (gw_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : gw_reg;
    assign gh_use = (gh_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : gh_reg;
    assign gd_use = (gd_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : gd_reg;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_x     = s_tdata[OP_W+COORD_W-1:OP_W];
    assign in_y     = s_tdata[OP_W+2*COORD_W-1:OP_W+COORD_W];
    assign in_z     = s_tdata[OP_W+3*COORD_W-1:OP_W+2*COORD_W];
    assign in_value = s_tdata[OP_W+3*COORD_W];

    assign in_hit = ({1'b0, in_x} < gw_use) && ({1'b0, in_y} < gh_use)
                    && ({1'b0, in_z} < gd_use);
    assign dims_nonzero = (gw_use != '0) && (gh_use != '0) && (gd_use != '0);

    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            xmask[i] = (DIM_W'(i) < gw_use);
        end
    end

    assign cell_row = cell_rdata & {ROW_W{valid_rd_reg}};
    assign lane_row = cell_row & xmask & {ROW_W{tap_ok_reg}};

    always_comb
    begin
        case (tap_reg)
            4'd0:    begin tap_dz = 2'd0; tap_dy = 2'd0; end
            4'd1:    begin tap_dz = 2'd0; tap_dy = 2'd1; end
            4'd2:    begin tap_dz = 2'd0; tap_dy = 2'd2; end
            4'd3:    begin tap_dz = 2'd1; tap_dy = 2'd0; end
            4'd4:    begin tap_dz = 2'd1; tap_dy = 2'd1; end
            4'd5:    begin tap_dz = 2'd1; tap_dy = 2'd2; end
            4'd6:    begin tap_dz = 2'd2; tap_dy = 2'd0; end
            4'd7:    begin tap_dz = 2'd2; tap_dy = 2'd1; end
            4'd8:    begin tap_dz = 2'd2; tap_dy = 2'd2; end
            default: begin tap_dz = 2'd1; tap_dy = 2'd1; end
        endcase
    end

    // An offset below zero wraps to all ones and so fails the range compare.
    assign tap_z = {1'b0, gz_reg} + DIM_W'(tap_dz) - DIM_W'(1);
    assign tap_y = {1'b0, gy_reg} + DIM_W'(tap_dy) - DIM_W'(1);

    assign gy_last = ({1'b0, gy_reg} + DIM_W'(1)) >= gh_use;
    assign gz_last = ({1'b0, gz_reg} + DIM_W'(1)) >= gd_use;
    assign gy_adv  = gy_last ? '0 : gy_reg + COORD_W'(1);
    assign gz_adv  = gy_last ? gz_reg + COORD_W'(1) : gz_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        value_next      = value_reg;
        gy_next         = gy_reg;
        gz_next         = gz_reg;
        tap_next        = tap_reg;
        acc_pend_next   = acc_pend_reg;
        tap_ok_next     = tap_ok_reg;
        tap_center_next = tap_center_reg;
        row_valid_next  = row_valid_reg;
        cp_pend_next    = cp_pend_reg;
        cp_addr_next    = cp_addr_reg;
        center_raw_next = center_raw_reg;
        res_value_next  = res_value_reg;
        res_oor_next    = res_oor_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_cell_next     = m_cell_reg;
        m_oor_next      = m_oor_reg;

        cell_raddr = {z_reg, y_reg};
        cell_we    = 1'b0;
        cell_waddr = cp_addr_reg;
        cell_wdata = nxt_rdata;
        nxt_we     = 1'b0;
        nxt_waddr  = {gz_reg, gy_reg};
        nxt_wdata  = (lane_next & xmask) | (center_raw_reg & ~xmask);
        nxt_raddr  = {gz_reg, gy_reg};

        lane_ctrl.clear  = 1'b0;
        lane_ctrl.accum  = acc_pend_reg;
        lane_ctrl.center = tap_center_reg;

        if (cp_pend_reg)
        begin
            cell_we = 1'b1;
            row_valid_next[cp_addr_reg] = 1'b1;
        end

        if (acc_pend_reg && tap_center_reg)
        begin
            center_raw_next = cell_row;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = in_op;
                    x_next     = in_x;
                    y_next     = in_y;
                    z_next     = in_z;
                    value_next = in_value;
                    cell_raddr = {in_z, in_y};
                    res_value_next = 1'b0;
                    res_oor_next   = 1'b0;
                    if ((in_op == OP_WRITE) || (in_op == OP_READ))
                    begin
                        if (in_hit)
                        begin
                            state_next = S_RW;
                        end
                        else
                        begin
                            res_oor_next = 1'b1;
                            state_next   = S_RESP;
                        end
                    end
                    else if ((in_op == OP_STEP) && dims_nonzero)
                    begin
                        gy_next    = '0;
                        gz_next    = '0;
                        tap_next   = '0;
                        state_next = S_GEN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RW:
            begin
                if (op_reg == OP_READ)
                begin
                    res_value_next = cell_row[x_reg];
                end
                else
                begin
                    cell_we    = 1'b1;
                    cell_waddr = {z_reg, y_reg};
                    cell_wdata = cell_row;
                    cell_wdata[x_reg] = value_reg;
                    row_valid_next[{z_reg, y_reg}] = 1'b1;
                end
                state_next = S_RESP;
            end
            S_GEN:
            begin
                if (tap_reg == TAP_DONE)
                begin
                    acc_pend_next = 1'b0;
                    state_next    = S_GEN_WR;
                end
                else
                begin
                    cell_raddr      = {tap_z[COORD_W-1:0], tap_y[COORD_W-1:0]};
                    tap_ok_next     = (tap_z < gd_use) && (tap_y < gh_use);
                    tap_center_next = (tap_reg == TAP_CENTER);
                    acc_pend_next   = 1'b1;
                    tap_next        = tap_reg + TAP_W'(1);
                    lane_ctrl.clear = (tap_reg == '0);
                end
            end
            S_GEN_WR:
            begin
                nxt_we   = 1'b1;
                tap_next = '0;
                if (gy_last && gz_last)
                begin
                    gy_next    = '0;
                    gz_next    = '0;
                    state_next = S_COPY;
                end
                else
                begin
                    gy_next    = gy_adv;
                    gz_next    = gz_adv;
                    state_next = S_GEN;
                end
            end
            S_COPY:
            begin
                cp_pend_next = 1'b1;
                cp_addr_next = {gz_reg, gy_reg};
                gy_next      = gy_adv;
                gz_next      = gz_adv;
                if (gy_last && gz_last)
                begin
                    state_next = S_COPY_END;
                end
            end
            S_COPY_END:
            begin
                cp_pend_next   = 1'b0;
                res_value_next = 1'b0;
                res_oor_next   = 1'b0;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_cell_next   = res_value_reg;
                    m_oor_next    = res_oor_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign valid_rd_next = row_valid_reg[cell_raddr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            z_reg          <= '0;
            value_reg      <= 1'b0;
            gy_reg         <= '0;
            gz_reg         <= '0;
            tap_reg        <= '0;
            acc_pend_reg   <= 1'b0;
            tap_ok_reg     <= 1'b0;
            tap_center_reg <= 1'b0;
            valid_rd_reg   <= 1'b0;
            row_valid_reg  <= '0;
            cp_pend_reg    <= 1'b0;
            cp_addr_reg    <= '0;
            center_raw_reg <= '0;
            res_value_reg  <= 1'b0;
            res_oor_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_cell_reg     <= 1'b0;
            m_oor_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            z_reg          <= z_next;
            value_reg      <= value_next;
            gy_reg         <= gy_next;
            gz_reg         <= gz_next;
            tap_reg        <= tap_next;
            acc_pend_reg   <= acc_pend_next;
            tap_ok_reg     <= tap_ok_next;
            tap_center_reg <= tap_center_next;
            valid_rd_reg   <= valid_rd_next;
            row_valid_reg  <= row_valid_next;
            cp_pend_reg    <= cp_pend_next;
            cp_addr_reg    <= cp_addr_next;
            center_raw_reg <= center_raw_next;
            res_value_reg  <= res_value_next;
            res_oor_reg    <= res_oor_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_cell_reg     <= m_cell_next;
            m_oor_reg      <= m_oor_next;
        end
    end

    l3g_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_COUNT)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    l3g_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_COUNT)
    ) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    l3g_lanes u_lanes (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .row      (lane_row),
        .live     (center_raw_reg & xmask),
        .next_row (lane_next)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, m_oor_reg, m_cell_reg};

    a_no_grid_write_in_gen: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == S_GEN) || (state_reg == S_GEN_WR)) |-> !cell_we)
        else $error("grid written while neighbors are being counted");

    a_lane_clear_alone: assert property (
        @(posedge clk) disable iff (!rst_n)
        lane_ctrl.clear |-> !lane_ctrl.accum)
        else $error("lane clear collides with accumulate");

    a_tap_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_GEN) |-> (tap_reg <= TAP_DONE))
        else $error("tap counter out of range");

    a_copy_window: assert property (
        @(posedge clk) disable iff (!rst_n)
        cp_pend_reg |-> ((state_reg == S_COPY) || (state_reg == S_COPY_END)))
        else $error("copy-back write outside the copy pass");

    a_result_from_resp: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_RESP))
        else $error("result loaded outside the response state");

endmodule

// ----- tb/life_3d_checker.sv -----
`timescale 1ns / 1ps

module life_3d_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // operation[1:0], x[5:2], y[9:6], z[13:10], value[14], zero[15]
    input  logic [l3g_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_value[0], out_of_range[1], zero[7:2]
    input  logic [l3g_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [l3g_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [l3g_pkg::DIM_W-1:0]       cfg_data,
    output int                              failures,
    output int                              outstanding,
    output int                              beats_checked
);

    import l3g_pkg::*;

    typedef struct packed {
        logic               pad;
        logic               value;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [OP_W-1:0]    op;
    } command_t;

    typedef struct packed {
        logic [OUT_TDATA_W-3:0] pad;
        logic                   out_of_range;
        logic                   cell_value;
    } outcome_t;

    // Cells are indexed [z][y][x].
    logic             cells [MAX_DIM][MAX_DIM][MAX_DIM];
    logic             fresh [MAX_DIM][MAX_DIM][MAX_DIM];
    logic [DIM_W-1:0] extent [3];
    outcome_t         awaited [$];

    function automatic int span(logic [CFG_INDEX_W-1:0] axis);
        return (extent[axis] > MAX_DIM) ? MAX_DIM : int'(extent[axis]);
    endfunction

    function automatic bit in_use(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 && x < span(CFG_GRID_WIDTH)
            && y < span(CFG_GRID_HEIGHT) && z < span(CFG_GRID_DEPTH);
    endfunction

    function automatic int live_around(int x, int y, int z);
        int n;
        n = 0;
        for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                    if ((dx != 0 || dy != 0 || dz != 0) && in_use(x + dx, y + dy, z + dz))
                        if (cells[z + dz][y + dy][x + dx])
                            n++;
        return n;
    endfunction

    function automatic void advance_generation();
        int w;
        int h;
        int d;
        int n;
        w = span(CFG_GRID_WIDTH);
        h = span(CFG_GRID_HEIGHT);
        d = span(CFG_GRID_DEPTH);
        for (int z = 0; z < d; z++)
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    n = live_around(x, y, z);
                    if (cells[z][y][x])
                        fresh[z][y][x] = (n == KEEP_COUNT) || (n == BIRTH_COUNT);
                    else
                        fresh[z][y][x] = (n == BIRTH_COUNT);
                end
        for (int z = 0; z < d; z++)
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                    cells[z][y][x] = fresh[z][y][x];
    endfunction

    function automatic outcome_t predict_outcome(command_t c);
        outcome_t r;
        r = '0;
        case (c.op)
            OP_WRITE, OP_READ:
            begin
                if (!in_use(c.x, c.y, c.z))
                    r.out_of_range = 1'b1;
                else if (c.op == OP_WRITE)
                    cells[c.z][c.y][c.x] = c.value;
                else
                    r.cell_value = cells[c.z][c.y][c.x];
            end
            OP_STEP:
                advance_generation();
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        failures++;
    endtask

    task automatic check_outcome(outcome_t got);
        outcome_t want;
        beats_checked++;
        if (awaited.size() == 0)
        begin
            report_mismatch("result beat with no command pending", int'(got), 0);
        end
        else
        begin
            want = awaited.pop_front();
            if (got.cell_value !== want.cell_value)
                report_mismatch("cell_value", got.cell_value, want.cell_value);
            if (got.out_of_range !== want.out_of_range)
                report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int z = 0; z < MAX_DIM; z++)
                for (int y = 0; y < MAX_DIM; y++)
                    for (int x = 0; x < MAX_DIM; x++)
                        cells[z][y][x] = 1'b0;
            extent[CFG_GRID_WIDTH]  = DIM_W'(MAX_DIM);
            extent[CFG_GRID_HEIGHT] = DIM_W'(MAX_DIM);
            extent[CFG_GRID_DEPTH]  = DIM_W'(MAX_DIM);
            awaited.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_GRID_DEPTH:
                        extent[cfg_index] = cfg_data;
                    default:
                        ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited.insert(awaited.size(), predict_outcome(command_t'(s_tdata)));
            if (m_tvalid && m_tready)
                check_outcome(outcome_t'(m_tdata));
            outstanding <= awaited.size();
        end
    end

endmodule

// ----- tb/life_3d_generation_step_test.sv -----
`timescale 1ns / 1ps

module life_3d_generation_step_test;

    import l3g_pkg::*;

    localparam logic [OP_W-1:0]        OP_NONE   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;

    int failures;
    int outstanding;
    int beats_checked;
    int tally [4];
    int settings;
    int dim_x = MAX_DIM;
    int dim_y = MAX_DIM;
    int dim_z = MAX_DIM;
    int hold_left = 0;
    bit steady = 1'b0;

    life_3d_generation_step uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    life_3d_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding),
        .beats_checked(beats_checked)
    );

    always #10 clk = ~clk;

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        if (r < 14)
            return $urandom_range(MAX_DIM + 1, 31);
        if (r < 22)
            return MAX_DIM;
        return $urandom_range(1, 6);
    endfunction

    function automatic int coord_within(int extent);
        if (extent == 0)
            return $urandom_range(0, MAX_DIM - 1);
        return $urandom_range(0, extent - 1);
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!steady && rst_n && $urandom_range(0, 99) < 25)
        begin
            hold_left <= stall_len() - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic issue(logic [OP_W-1:0] op, int x, int y, int z, bit v);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 45) ? 0 : stall_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v, 4'(z), 4'(y), 4'(x), op};
        do @(posedge clk); while (!s_tready);
        tally[op]++;
    endtask

    task automatic settle(int extra);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_grid(int w, int h, int d);
        settle(4);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(posedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(posedge clk);
        cfg_index <= CFG_GRID_DEPTH;
        cfg_data  <= DIM_W'(d);
        @(posedge clk);
        if ($urandom_range(0, 1) == 1)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= DIM_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        dim_x = (w > MAX_DIM) ? MAX_DIM : w;
        dim_y = (h > MAX_DIM) ? MAX_DIM : h;
        dim_z = (d > MAX_DIM) ? MAX_DIM : d;
        settings++;
    endtask

    task automatic random_command(bit seeding);
        int r;
        r = seeding ? 0 : $urandom_range(0, 99);
        if (r < 40)
            issue(OP_WRITE, coord_within(dim_x), coord_within(dim_y), coord_within(dim_z),
                  $urandom_range(0, 99) < 55);
        else if (r < 70)
            issue(OP_READ, coord_within(dim_x), coord_within(dim_y), coord_within(dim_z), 1'b0);
        else if (r < 82)
            issue(OP_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 1));
        else if (r < 94)
            issue($urandom_range(0, 1) ? OP_READ : OP_WRITE, $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
        else
            issue(OP_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 1));
    endtask

    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_READ, 0, 0, 0, 1'b0);
        issue(OP_READ, 15, 15, 15, 1'b0);
        issue(OP_NONE, 15, 15, 15, 1'b1);
        issue(OP_WRITE, 0, 0, 0, 1'b1);
        issue(OP_WRITE, 1, 0, 0, 1'b1);
        issue(OP_WRITE, 2, 0, 0, 1'b1);
        issue(OP_STEP, 0, 0, 0, 1'b0);
        issue(OP_READ, 1, 0, 0, 1'b0);
        issue(OP_READ, 0, 0, 0, 1'b0);
        issue(OP_READ, 1, 1, 0, 1'b0);
        issue(OP_WRITE, 15, 15, 15, 1'b1);
        issue(OP_READ, 15, 15, 15, 1'b0);

        set_grid(5, 3, 7);
        issue(OP_WRITE, 4, 2, 6, 1'b1);
        issue(OP_WRITE, 5, 0, 0, 1'b1);
        issue(OP_READ, 0, 3, 0, 1'b0);
        issue(OP_READ, 0, 0, 7, 1'b0);
        issue(OP_STEP, 15, 15, 15, 1'b1);
        issue(OP_READ, 4, 2, 6, 1'b0);

        set_grid(0, MAX_DIM, MAX_DIM);
        issue(OP_WRITE, 0, 0, 0, 1'b1);
        issue(OP_READ, 0, 0, 0, 1'b0);
        issue(OP_STEP, 0, 0, 0, 1'b0);

        set_grid(31, 31, 31);
        issue(OP_READ, 15, 15, 15, 1'b0);
        issue(OP_STEP, 0, 0, 0, 1'b0);
        issue(OP_READ, 1, 1, 0, 1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            set_grid(pick_dim(), pick_dim(), pick_dim());
            steady = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < 15; k++)
                random_command(k < 4);
        end
        steady = 1'b0;

        settle(20);
        $display("Sent %0d commands: %0d writes, %0d reads, %0d generations, %0d no-ops.",
                 tally[OP_WRITE] + tally[OP_READ] + tally[OP_STEP] + tally[OP_NONE],
                 tally[OP_WRITE], tally[OP_READ], tally[OP_STEP], tally[OP_NONE]);
        $display("Checked %0d result beats over %0d grid sizes, including empty and clamped.",
                 beats_checked, settings);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
